FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files of the array hash block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication in the same cycle, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion violated");

// Checks an implication in the next cycle, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion violated");

`endif

FILE: rtl/mmh64a_pkg.sv
// Package for the array hash block: hash constants, codes and sequencer types.
// Depends on nothing; used by murmur64a_array_hash.
`timescale 1ns / 1ps

package mmh64a_pkg;

   localparam logic [63:0] HASH_MULT  = 64'hc6a4a7935bd1e995;
   localparam logic [31:0] MULT_LO    = HASH_MULT[31:0];
   localparam logic [31:0] MULT_HI    = HASH_MULT[63:32];
   localparam int          HASH_SHIFT = 47;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;

   localparam logic CSR_SEED = 1'b0;
   localparam logic CSR_SIZE = 1'b1;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_PRE  = 7'b0000010,
      S_INS  = 7'b0000100,
      S_LAST = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_FIN  = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      K_WORD,
      K_KEY,
      K_HASH,
      K_FIN
   } kind_type;

   function automatic logic [3:0] lane_count(input logic [1:0] size);
      logic [3:0] n;
      case (size)
         SIZE_BYTE: n = 4'd8;
         SIZE_HALF: n = 4'd4;
         default:   n = 4'd2;
      endcase
      return n;
   endfunction

   function automatic logic [63:0] fold(input logic [63:0] x);
      return x ^ (x >> HASH_SHIFT);
   endfunction

endpackage

FILE: rtl/murmur64a_array_hash.sv
// Top level of the array hash block: sequencer, shared 32x32 multiplier and streams.
// Depends on mmh64a_pkg and assert_macros.svh.
`timescale 1ns / 1ps

// The block hashes a stream of 8-, 16- or 32-bit array elements, one element per
// request, with a MurmurHash64A variant and returns one 64-bit digest per array on
// the request that carries tlast. Elements are sign-extended and packed into 64-bit
// words; a word mix runs three 64-bit multiplies, one after another, on one shared
// 32x32 multiplier. A request that completes a word runs a mix before the block takes
// another, and the last request of an array adds one more mix for a partial word and
// a finalization, the last step of which loads the digest into the output register.
// The block accepts no request while it works on one, but does accept one while a
// digest waits to be taken.
module murmur64a_array_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // element_value [31:0], element_count [63:32]
   input  logic [1:0]  req_tuser,  // is_first [0], is_empty [1]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // digest [63:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   mmh64a_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   mmh64a_pkg::kind_type  kind_ff, kind_in;
   logic [1:0]  phase_ff, phase_in;
   logic [63:0] hash_ff, hash_in, acc_ff, acc_in, op_ff, op_in, key_ff, key_in;
   logic [63:0] prod_ff, prod_in, sum_ff, sum_in, digest_ff, digest_in;
   logic [63:0] seed_ff, seed_in;
   logic [1:0]  size_ff, size_in;
   logic [2:0]  lane_ff, lane_in;
   logic        in_array_ff, in_array_in, rsp_valid_ff, rsp_valid_in;
   logic [31:0] value_ff, value_in;
   logic        last_ff, last_in, empty_ff, empty_in;

   logic        req_fire;
   logic        req_start;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_result, elem_ext, acc_ins;
   logic [5:0]  shamt;
   logic [3:0]  lanes, lane_wide, lane_next;

   assign req_tready = (state_ff == mmh64a_pkg::S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_start  = req_fire & (req_tuser[0] | in_array_ff);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = digest_ff;

   assign mul_a      = (phase_ff == 2'd2) ? op_ff[63:32] : op_ff[31:0];
   assign mul_b      = (phase_ff == 2'd1) ? mmh64a_pkg::MULT_HI : mmh64a_pkg::MULT_LO;
   assign prod_in    = 64'(mul_a) * 64'(mul_b);
   assign mul_result = sum_ff + {prod_ff[31:0], 32'd0};

   assign lanes     = mmh64a_pkg::lane_count(size_ff);
   assign lane_wide = {1'b0, lane_ff};
   assign lane_next = lane_wide + 4'd1;

   always_comb begin
      case (size_ff)
         mmh64a_pkg::SIZE_BYTE: begin
            elem_ext = {{56{value_ff[7]}}, value_ff[7:0]};
            shamt    = {lane_ff, 3'd0};
         end
         mmh64a_pkg::SIZE_HALF: begin
            elem_ext = {{48{value_ff[15]}}, value_ff[15:0]};
            shamt    = {lane_ff[1:0], 4'd0};
         end
         default: begin
            elem_ext = {{32{value_ff[31]}}, value_ff};
            shamt    = {lane_ff[0], 5'd0};
         end
      endcase
      acc_ins = acc_ff | (elem_ext << shamt);
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      kind_in      = kind_ff;
      phase_in     = phase_ff;
      hash_in      = hash_ff;
      acc_in       = acc_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      sum_in       = sum_ff;
      digest_in    = digest_ff;
      seed_in      = seed_ff;
      size_in      = size_ff;
      lane_in      = lane_ff;
      in_array_in  = in_array_ff;
      rsp_valid_in = rsp_valid_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;

      if (csr_valid) begin
         case (csr_index)
            mmh64a_pkg::CSR_SEED: seed_in = csr_data;
            mmh64a_pkg::CSR_SIZE: size_in = csr_data[1:0];
            default:              seed_in = seed_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         mmh64a_pkg::S_IDLE: begin
            if (req_fire) begin
               value_in = req_tdata[31:0];
               last_in  = req_tlast;
               empty_in = req_tuser[1];
               if (req_tuser[0]) begin
                  hash_in     = seed_ff ^ (req_tuser[1] ? 64'd0 : {32'd0, req_tdata[63:32]});
                  acc_in      = '0;
                  lane_in     = '0;
                  in_array_in = 1'b1;
                  state_in    = mmh64a_pkg::S_PRE;
               end else if (in_array_ff) begin
                  state_in = mmh64a_pkg::S_PRE;
               end
            end
         end
         mmh64a_pkg::S_PRE: begin
            state_in = mmh64a_pkg::S_INS;
            if (!empty_ff && lane_wide >= lanes) begin
               op_in    = acc_ff;
               acc_in   = '0;
               lane_in  = '0;
               kind_in  = mmh64a_pkg::K_WORD;
               phase_in = 2'd0;
               ret_in   = mmh64a_pkg::S_INS;
               state_in = mmh64a_pkg::S_MUL;
            end
         end
         mmh64a_pkg::S_INS: begin
            state_in = mmh64a_pkg::S_LAST;
            if (!empty_ff) begin
               if (lane_next >= lanes) begin
                  op_in    = acc_ins;
                  acc_in   = '0;
                  lane_in  = '0;
                  kind_in  = mmh64a_pkg::K_WORD;
                  phase_in = 2'd0;
                  ret_in   = mmh64a_pkg::S_LAST;
                  state_in = mmh64a_pkg::S_MUL;
               end else begin
                  acc_in  = acc_ins;
                  lane_in = lane_next[2:0];
               end
            end
         end
         mmh64a_pkg::S_LAST: begin
            if (!last_ff) begin
               state_in = mmh64a_pkg::S_IDLE;
            end else if (lane_ff != 3'd0) begin
               op_in    = acc_ff;
               kind_in  = mmh64a_pkg::K_WORD;
               phase_in = 2'd0;
               ret_in   = mmh64a_pkg::S_FIN;
               state_in = mmh64a_pkg::S_MUL;
            end else begin
               state_in = mmh64a_pkg::S_FIN;
            end
         end
         mmh64a_pkg::S_FIN: begin
            op_in       = mmh64a_pkg::fold(hash_ff);
            kind_in     = mmh64a_pkg::K_FIN;
            phase_in    = 2'd0;
            acc_in      = '0;
            lane_in     = '0;
            in_array_in = 1'b0;
            state_in    = mmh64a_pkg::S_MUL;
         end
         mmh64a_pkg::S_MUL: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd1) begin
               sum_in = prod_ff;
            end else if (phase_ff == 2'd2) begin
               sum_in = mul_result;
            end else if (phase_ff == 2'd3) begin
               case (kind_ff)
                  mmh64a_pkg::K_WORD: begin
                     op_in   = mmh64a_pkg::fold(mul_result);
                     kind_in = mmh64a_pkg::K_KEY;
                  end
                  mmh64a_pkg::K_KEY: begin
                     key_in  = mul_result;
                     op_in   = hash_ff;
                     kind_in = mmh64a_pkg::K_HASH;
                  end
                  mmh64a_pkg::K_HASH: begin
                     hash_in  = mul_result ^ key_ff;
                     state_in = ret_ff;
                  end
                  default: begin
                     key_in   = mmh64a_pkg::fold(mul_result);
                     state_in = mmh64a_pkg::S_OUT;
                  end
               endcase
            end
         end
         mmh64a_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               digest_in    = key_ff;
               rsp_valid_in = 1'b1;
               state_in     = mmh64a_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mmh64a_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmh64a_pkg::S_IDLE;
         phase_ff     <= 2'd0;
         hash_ff      <= '0;
         acc_ff       <= '0;
         lane_ff      <= '0;
         in_array_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= '0;
         size_ff      <= mmh64a_pkg::SIZE_BYTE;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         hash_ff      <= hash_in;
         acc_ff       <= acc_in;
         lane_ff      <= lane_in;
         in_array_ff  <= in_array_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_ff      <= seed_in;
         size_ff      <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff    <= ret_in;
      kind_ff   <= kind_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      prod_ff   <= prod_in;
      sum_ff    <= sum_in;
      digest_ff <= digest_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
   end

`include "assert_macros.svh"

   `ASSERT_NEXT(a_busy_after_request, clock, reset, req_start, !req_tready)
   `ASSERT_SAME(a_idle_word_clear, clock, reset, req_tready && !in_array_ff, lane_ff == 3'd0 && acc_ff == 64'd0)
   `ASSERT_SAME(a_digest_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff == mmh64a_pkg::S_OUT))

endmodule
